// File: design/hsdr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsdr_pkg
// Shared types, constants and the quarter-wave sine table of the
// heading/speed dead-reckoning integrator.
// ----------------------------------------------------------------------------
package hsdr_pkg;

    localparam int SINE_TABLE_BITS = 10;
    localparam int QIDX_W          = SINE_TABLE_BITS - 2;
    localparam int QSIZE           = 1 << QIDX_W;
    localparam int MAG_W           = 17;
    localparam int PROD_W          = 32 + MAG_W;

    localparam logic [63:0] C1 = 64'd1686629713;
    localparam logic [63:0] C3 = 64'd693598668;
    localparam logic [63:0] C5 = 64'd85569306;
    localparam logic [63:0] C7 = 64'd5026995;
    localparam logic [63:0] C9 = 64'd172272;

    localparam logic [MAG_W-1:0] MAG_ONE = MAG_W'(65536);

    // register indexes
    localparam logic [1:0] REG_TURN_RATE  = 2'd0;
    localparam logic [1:0] REG_ACCEL_RATE = 2'd1;
    localparam logic [1:0] REG_MAX_SPEED  = 2'd2;

    localparam logic [15:0] TURN_RATE_RST  = 16'd16384;
    localparam logic [31:0] ACCEL_RATE_RST = 32'd65536;
    localparam logic [31:0] MAX_SPEED_RST  = 32'd655360;

    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic [15:0] turn_rate;
        logic [31:0] accel_rate;
        logic [31:0] max_speed;
    } cfg_t;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_LOAD,
        DP_MUL_DH,
        DP_MUL_DS,
        DP_SPEED,
        DP_MUL_DIST,
        DP_DIST,
        DP_MUL_X,
        DP_MUL_Y,
        DP_POS_Y
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   out_load;
    } dp_cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_DH,
        S_MUL_DS,
        S_SPEED,
        S_MUL_DIST,
        S_DIST,
        S_MUL_X,
        S_MUL_Y,
        S_POS_Y,
        S_RESULT
    } ctrl_state_t;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } sine_t;

    typedef logic [MAG_W-1:0] sine_lut_t [0:QSIZE-1];

    // degree-9 odd polynomial of sin(pi/2*t), q0.30, rounded to q1.16
    function automatic logic [MAG_W-1:0] quarter_sine(input logic [63:0] k);
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] p;
        logic [63:0] s;
        t  = k << (32 - SINE_TABLE_BITS);
        t2 = (t * t) >> 30;
        p  = C7 - ((t2 * C9) >> 30);
        p  = C5 - ((t2 * p) >> 30);
        p  = C3 - ((t2 * p) >> 30);
        p  = C1 - ((t2 * p) >> 30);
        s  = (t * p) >> 30;
        s  = (s + 64'd8192) >> 14;
        if (s > 64'd65536) begin
            s = 64'd65536;
        end
        return s[MAG_W-1:0];
    endfunction

    function automatic sine_lut_t build_sine_lut();
        sine_lut_t lut;
        for (int i = 0; i < QSIZE; i++) begin
            lut[i] = quarter_sine(64'(i));
        end
        return lut;
    endfunction

    localparam sine_lut_t SINE_LUT = build_sine_lut();

    function automatic sine_t sine_of(input logic [SINE_TABLE_BITS-1:0] idx);
        sine_t             r;
        logic [1:0]        quad;
        logic [QIDX_W-1:0] k;
        logic [QIDX_W-1:0] k_m;
        quad  = idx[SINE_TABLE_BITS-1 -: 2];
        k     = idx[QIDX_W-1:0];
        k_m   = ~k + {{(QIDX_W-1){1'b0}}, 1'b1};
        r.neg = quad[1];
        if (quad[0]) begin
            r.mag = (k == '0) ? MAG_ONE : SINE_LUT[k_m];
        end else begin
            r.mag = SINE_LUT[k];
        end
        return r;
    endfunction

endpackage

// File: design/heading_speed_dead_reckoning.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_speed_dead_reckoning
// Dead-reckoning vehicle integrator: key flags, heading, speed, X/Y position.
// ----------------------------------------------------------------------------
// A key transaction (tuser 0) latches the accelerate/left/right flags and
// returns the state; a tick transaction (tuser 1) turns, accelerates and
// moves the vehicle by frame_delay and returns the new state. A tick makes
// five passes through a single shared 32x17 multiplier, which sets the tick
// time. The next transaction is accepted as soon as the result is in the
// output register, even while it still waits for m_tready. Registers at byte
// addresses 0 (turn_rate), 4 (accel_rate) and 8 (max_speed) are to be written
// only while the block is idle; the block itself does not enforce this.
module heading_speed_dead_reckoning (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    // key_accelerate, key_left, key_right, frame_delay[15:0], zero pad
    input  logic [23:0]  s_tdata,
    // cmd
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // pos_x[31:0], pos_y[31:0], heading[15:0], speed[31:0]
    output logic [111:0] m_tdata
);

    hsdr_pkg::cfg_t    cfg;
    hsdr_pkg::dp_cmd_t dp_cmd;
    logic [31:0]       pos_x;
    logic [31:0]       pos_y;
    logic [15:0]       heading;
    logic [31:0]       speed;

    hsdr_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hsdr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_cmd    (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .dp_cmd   (dp_cmd)
    );

    hsdr_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg),
        .dp_cmd           (dp_cmd),
        .s_cmd            (s_tuser),
        .s_key_accelerate (s_tdata[0]),
        .s_key_left       (s_tdata[1]),
        .s_key_right      (s_tdata[2]),
        .s_frame_delay    (s_tdata[18:3]),
        .pos_x            (pos_x),
        .pos_y            (pos_y),
        .heading          (heading),
        .speed            (speed)
    );

    assign m_tdata = {speed, heading, pos_y, pos_x};

endmodule

// File: design/hsdr_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsdr_regs
// APB configuration registers: turn rate, acceleration rate, speed ceiling.
// ----------------------------------------------------------------------------
module hsdr_regs (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output hsdr_pkg::cfg_t      cfg
);

    hsdr_pkg::cfg_t cfg_reg;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.turn_rate  <= hsdr_pkg::TURN_RATE_RST;
            cfg_reg.accel_rate <= hsdr_pkg::ACCEL_RATE_RST;
            cfg_reg.max_speed  <= hsdr_pkg::MAX_SPEED_RST;
        end else if (wr_en) begin
            case (paddr[3:2])
                hsdr_pkg::REG_TURN_RATE:  cfg_reg.turn_rate  <= pwdata[15:0];
                hsdr_pkg::REG_ACCEL_RATE: cfg_reg.accel_rate <= pwdata;
                hsdr_pkg::REG_MAX_SPEED:  cfg_reg.max_speed  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            hsdr_pkg::REG_TURN_RATE:  prdata = {16'd0, cfg_reg.turn_rate};
            hsdr_pkg::REG_ACCEL_RATE: prdata = cfg_reg.accel_rate;
            hsdr_pkg::REG_MAX_SPEED:  prdata = cfg_reg.max_speed;
            default:                  prdata = 32'd0;
        endcase
    end

endmodule

// File: design/hsdr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsdr_ctrl
// Sequencer: steps the datapath through a key load or one tick and owns the handshakes.
// ----------------------------------------------------------------------------
module hsdr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_cmd,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output hsdr_pkg::dp_cmd_t dp_cmd
);

    hsdr_pkg::ctrl_state_t state_reg;
    hsdr_pkg::ctrl_state_t state_next;
    logic                  m_tvalid_reg;
    logic                  m_tvalid_next;

    assign m_tvalid = m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= hsdr_pkg::S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        s_tready        = 1'b0;
        dp_cmd.op       = hsdr_pkg::DP_NONE;
        dp_cmd.out_load = 1'b0;
        case (state_reg)
            hsdr_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    dp_cmd.op  = hsdr_pkg::DP_LOAD;
                    state_next = (s_cmd == hsdr_pkg::CMD_TICK) ? hsdr_pkg::S_MUL_DH
                                                               : hsdr_pkg::S_RESULT;
                end
            end
            hsdr_pkg::S_MUL_DH: begin
                dp_cmd.op  = hsdr_pkg::DP_MUL_DH;
                state_next = hsdr_pkg::S_MUL_DS;
            end
            hsdr_pkg::S_MUL_DS: begin
                dp_cmd.op  = hsdr_pkg::DP_MUL_DS;
                state_next = hsdr_pkg::S_SPEED;
            end
            hsdr_pkg::S_SPEED: begin
                dp_cmd.op  = hsdr_pkg::DP_SPEED;
                state_next = hsdr_pkg::S_MUL_DIST;
            end
            hsdr_pkg::S_MUL_DIST: begin
                dp_cmd.op  = hsdr_pkg::DP_MUL_DIST;
                state_next = hsdr_pkg::S_DIST;
            end
            hsdr_pkg::S_DIST: begin
                dp_cmd.op  = hsdr_pkg::DP_DIST;
                state_next = hsdr_pkg::S_MUL_X;
            end
            hsdr_pkg::S_MUL_X: begin
                dp_cmd.op  = hsdr_pkg::DP_MUL_X;
                state_next = hsdr_pkg::S_MUL_Y;
            end
            hsdr_pkg::S_MUL_Y: begin
                dp_cmd.op  = hsdr_pkg::DP_MUL_Y;
                state_next = hsdr_pkg::S_POS_Y;
            end
            hsdr_pkg::S_POS_Y: begin
                dp_cmd.op  = hsdr_pkg::DP_POS_Y;
                state_next = hsdr_pkg::S_RESULT;
            end
            hsdr_pkg::S_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    dp_cmd.out_load = 1'b1;
                    m_tvalid_next   = 1'b1;
                    state_next      = hsdr_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = hsdr_pkg::S_IDLE;
            end
        endcase
    end

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while busy");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result overwritten");

    a_key_direct: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_cmd == hsdr_pkg::CMD_KEY)
            |=> state_reg == hsdr_pkg::S_RESULT)
        else $error("key transaction not sent to result");

endmodule

// File: design/hsdr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsdr_dp
// Datapath: vehicle state, one shared 32x17 multiplier, sine lookup,
// result register.
// ----------------------------------------------------------------------------
module hsdr_dp (
    input  logic              aclk,
    input  logic              aresetn,
    input  hsdr_pkg::cfg_t    cfg,
    input  hsdr_pkg::dp_cmd_t dp_cmd,
    input  logic              s_cmd,
    input  logic              s_key_accelerate,
    input  logic              s_key_left,
    input  logic              s_key_right,
    input  logic [15:0]       s_frame_delay,
    output logic [31:0]       pos_x,
    output logic [31:0]       pos_y,
    output logic [15:0]       heading,
    output logic [31:0]       speed
);

    logic                           flag_acc_reg;
    logic                           flag_left_reg;
    logic                           flag_right_reg;
    logic [15:0]                    heading_reg;
    logic [15:0]                    heading_next;
    logic [31:0]                    speed_reg;
    logic [31:0]                    speed_next;
    logic [31:0]                    x_reg;
    logic [31:0]                    y_reg;
    logic [15:0]                    delay_reg;
    logic [31:0]                    dist_reg;
    hsdr_pkg::sine_t                sin_x_reg;
    hsdr_pkg::sine_t                sin_y_reg;
    logic [hsdr_pkg::PROD_W-1:0]    prod_reg;
    logic [31:0]                    mul_a;
    logic [hsdr_pkg::MAG_W-1:0]     mul_b;
    logic [hsdr_pkg::PROD_W-1:0]    mul_p;
    logic [15:0]                    dh;
    logic [31:0]                    prod_mid;
    logic [32:0]                    sp_sum;
    logic [32:0]                    sp_raw;
    logic [hsdr_pkg::SINE_TABLE_BITS-1:0] idx_x;
    logic [hsdr_pkg::SINE_TABLE_BITS-1:0] idx_y;
    logic [31:0]                    out_x_reg;
    logic [31:0]                    out_y_reg;
    logic [15:0]                    out_h_reg;
    logic [31:0]                    out_s_reg;

    assign dh       = prod_reg[31:16];
    assign prod_mid = prod_reg[47:16];

    always_comb begin
        case (dp_cmd.op)
            hsdr_pkg::DP_MUL_DH: begin
                mul_a = {16'd0, cfg.turn_rate};
                mul_b = {1'b0, delay_reg};
            end
            hsdr_pkg::DP_MUL_DS: begin
                mul_a = cfg.accel_rate;
                mul_b = {1'b0, delay_reg};
            end
            hsdr_pkg::DP_MUL_DIST: begin
                mul_a = speed_reg;
                mul_b = {1'b0, delay_reg};
            end
            hsdr_pkg::DP_MUL_X: begin
                mul_a = dist_reg;
                mul_b = sin_x_reg.mag;
            end
            default: begin
                mul_a = dist_reg;
                mul_b = sin_y_reg.mag;
            end
        endcase
        mul_p = hsdr_pkg::PROD_W'(mul_a) * hsdr_pkg::PROD_W'(mul_b);
    end

    always_comb begin
        heading_next = heading_reg;
        if (flag_left_reg) begin
            heading_next = heading_next + dh;
        end
        if (flag_right_reg) begin
            heading_next = heading_next - dh;
        end
    end

    always_comb begin
        sp_sum = {1'b0, speed_reg} + {1'b0, prod_mid};
        if (flag_acc_reg) begin
            sp_raw = sp_sum;
        end else if (prod_mid > speed_reg) begin
            sp_raw = 33'd0;
        end else begin
            sp_raw = {1'b0, speed_reg - prod_mid};
        end
        speed_next = (sp_raw > {1'b0, cfg.max_speed}) ? cfg.max_speed : sp_raw[31:0];
    end

    assign idx_x = heading_reg[15 -: hsdr_pkg::SINE_TABLE_BITS];
    assign idx_y = {idx_x[hsdr_pkg::SINE_TABLE_BITS-1 -: 2] + 2'd1,
                    idx_x[hsdr_pkg::QIDX_W-1:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_acc_reg   <= 1'b0;
            flag_left_reg  <= 1'b0;
            flag_right_reg <= 1'b0;
            heading_reg    <= 16'd0;
            speed_reg      <= 32'd0;
            x_reg          <= 32'd0;
            y_reg          <= 32'd0;
        end else begin
            case (dp_cmd.op)
                hsdr_pkg::DP_LOAD: begin
                    if (s_cmd == hsdr_pkg::CMD_KEY) begin
                        flag_acc_reg   <= s_key_accelerate;
                        flag_left_reg  <= s_key_left;
                        flag_right_reg <= s_key_right;
                    end
                end
                hsdr_pkg::DP_MUL_DS: heading_reg <= heading_next;
                hsdr_pkg::DP_SPEED:  speed_reg   <= speed_next;
                hsdr_pkg::DP_MUL_Y: begin
                    x_reg <= sin_x_reg.neg ? x_reg + prod_mid : x_reg - prod_mid;
                end
                hsdr_pkg::DP_POS_Y: begin
                    y_reg <= sin_y_reg.neg ? y_reg + prod_mid : y_reg - prod_mid;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.op == hsdr_pkg::DP_LOAD) begin
            delay_reg <= s_frame_delay;
        end
        if (dp_cmd.op == hsdr_pkg::DP_MUL_DH || dp_cmd.op == hsdr_pkg::DP_MUL_DS ||
            dp_cmd.op == hsdr_pkg::DP_MUL_DIST || dp_cmd.op == hsdr_pkg::DP_MUL_X ||
            dp_cmd.op == hsdr_pkg::DP_MUL_Y) begin
            prod_reg <= mul_p;
        end
        if (dp_cmd.op == hsdr_pkg::DP_MUL_DIST) begin
            sin_x_reg <= hsdr_pkg::sine_of(idx_x);
            sin_y_reg <= hsdr_pkg::sine_of(idx_y);
        end
        if (dp_cmd.op == hsdr_pkg::DP_DIST) begin
            dist_reg <= prod_mid;
        end
        if (dp_cmd.out_load) begin
            out_x_reg <= x_reg;
            out_y_reg <= y_reg;
            out_h_reg <= heading_reg;
            out_s_reg <= speed_reg;
        end
    end

    assign pos_x   = out_x_reg;
    assign pos_y   = out_y_reg;
    assign heading = out_h_reg;
    assign speed   = out_s_reg;

    a_speed_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        (dp_cmd.op == hsdr_pkg::DP_SPEED) |=> (speed_reg <= $past(cfg.max_speed)))
        else $error("speed above ceiling");

    a_key_keeps_heading: assert property (@(posedge aclk) disable iff (!aresetn)
        (dp_cmd.op == hsdr_pkg::DP_LOAD) |=> (heading_reg == $past(heading_reg)))
        else $error("heading moved on load");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dead-reckoning integrator. Key and tick
// transactions go in on the input stream, and a bit-accurate model of the
// flags, heading, speed and X/Y position predicts every output transaction,
// which is compared field by field. Directed items cover the field extremes,
// turning in both directions, the speed clamps and the register extremes.
// Random phases with new register settings follow, with bursts of idle
// cycles on both streams.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LIMIT_CYCLES = 400000;
    localparam int TAIL_CYCLES  = 24;

    localparam logic [63:0] POLY_A1 = 64'd1686629713;
    localparam logic [63:0] POLY_A3 = 64'd693598668;
    localparam logic [63:0] POLY_A5 = 64'd85569306;
    localparam logic [63:0] POLY_A7 = 64'd5026995;
    localparam logic [63:0] POLY_A9 = 64'd172272;

    localparam logic [2:0] KEYS_NONE  = 3'b000;
    localparam logic [2:0] KEY_ACCEL  = 3'b001;
    localparam logic [2:0] KEY_LEFT   = 3'b010;
    localparam logic [2:0] KEY_RIGHT  = 3'b100;

    typedef struct {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [15:0] heading;
        logic [31:0] speed;
    } nav_state_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         psel     = 1'b0;
    logic         penable  = 1'b0;
    logic         pwrite   = 1'b0;
    logic [3:0]   paddr    = '0;
    logic [31:0]  pwdata   = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // key_accelerate, key_left, key_right, frame_delay[15:0], zero pad
    logic [23:0]  s_tdata  = '0;
    // cmd
    logic         s_tuser  = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b1;
    // pos_x[31:0], pos_y[31:0], heading[15:0], speed[31:0]
    logic [111:0] m_tdata;

    // model of the block
    logic [15:0] turn_rate_m;
    logic [31:0] accel_rate_m;
    logic [31:0] max_speed_m;
    logic        accel_flag_m;
    logic        left_flag_m;
    logic        right_flag_m;
    logic [15:0] heading_m;
    logic [31:0] speed_m;
    logic [31:0] pos_x_m;
    logic [31:0] pos_y_m;

    nav_state_t expected_states[$];
    int         error_count = 0;
    int         cycle_count = 0;
    int         stall_left  = 0;
    bit         quiet       = 1'b0;

    heading_speed_dead_reckoning dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("%0t timeout after %0d cycles", $time, cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // output stream back-pressure
    always @(posedge aclk) begin
        if (quiet) begin
            stall_left = 0;
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 9);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // sine magnitude in q1.16 for a quarter-wave step 0..2^(bits-2)
    function automatic logic [63:0] quarter_wave_mag(input logic [63:0] step);
        logic [63:0] t;
        logic [63:0] t_sq;
        logic [63:0] acc;
        t    = step << (32 - hsdr_pkg::SINE_TABLE_BITS);
        t_sq = (t * t) >> 30;
        acc  = POLY_A7 - ((t_sq * POLY_A9) >> 30);
        acc  = POLY_A5 - ((t_sq * acc) >> 30);
        acc  = POLY_A3 - ((t_sq * acc) >> 30);
        acc  = POLY_A1 - ((t_sq * acc) >> 30);
        acc  = (t * acc) >> 30;
        acc  = (acc + 64'd8192) >> 14;
        return (acc > 64'd65536) ? 64'd65536 : acc;
    endfunction

    // moves one coordinate against the sine of the given phase index
    function automatic logic [31:0] move_axis(
        input logic [31:0] pos,
        input logic [hsdr_pkg::SINE_TABLE_BITS-1:0] phase,
        input logic [63:0] travel);
        logic [1:0]  quad;
        logic [63:0] k;
        logic [63:0] mag;
        logic [63:0] prod;
        quad = phase[hsdr_pkg::SINE_TABLE_BITS-1 -: 2];
        k    = 64'(phase[hsdr_pkg::SINE_TABLE_BITS-3:0]);
        mag  = quarter_wave_mag(quad[0] ? (64'(1 << (hsdr_pkg::SINE_TABLE_BITS - 2)) - k)
                                        : k);
        prod = (mag * travel) >> 16;
        return quad[1] ? pos + prod[31:0] : pos - prod[31:0];
    endfunction

    function automatic void advance_vehicle(input logic cmd, input logic [2:0] keys,
                                            input logic [15:0] delay);
        logic [63:0] dh;
        logic [63:0] ds;
        logic [63:0] sp;
        logic [63:0] travel;
        logic [hsdr_pkg::SINE_TABLE_BITS-1:0] phase;
        nav_state_t  st;
        if (cmd == hsdr_pkg::CMD_KEY) begin
            accel_flag_m = keys[0];
            left_flag_m  = keys[1];
            right_flag_m = keys[2];
        end else begin
            dh = (64'(turn_rate_m) * 64'(delay)) >> 16;
            ds = (64'(accel_rate_m) * 64'(delay)) >> 16;
            if (left_flag_m) heading_m = heading_m + dh[15:0];
            if (right_flag_m) heading_m = heading_m - dh[15:0];
            if (accel_flag_m) begin
                sp = 64'(speed_m) + ds;
            end else begin
                sp = (ds > 64'(speed_m)) ? 64'd0 : 64'(speed_m) - ds;
            end
            if (sp > 64'(max_speed_m)) sp = 64'(max_speed_m);
            speed_m = sp[31:0];
            travel  = (64'(speed_m) * 64'(delay)) >> 16;
            phase   = heading_m[15 -: hsdr_pkg::SINE_TABLE_BITS];
            pos_x_m = move_axis(pos_x_m, phase, travel);
            phase   = phase + hsdr_pkg::SINE_TABLE_BITS'(1 << (hsdr_pkg::SINE_TABLE_BITS - 2));
            pos_y_m = move_axis(pos_y_m, phase, travel);
        end
        st.pos_x   = pos_x_m;
        st.pos_y   = pos_y_m;
        st.heading = heading_m;
        st.speed   = speed_m;
        expected_states.push_back(st);
    endfunction

    always @(posedge aclk) begin
        nav_state_t want;
        nav_state_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.pos_x   = m_tdata[31:0];
            got.pos_y   = m_tdata[63:32];
            got.heading = m_tdata[79:64];
            got.speed   = m_tdata[111:80];
            if (expected_states.size() == 0) begin
                $display("%0t unexpected transaction: x %h y %h heading %h speed %h",
                         $time, got.pos_x, got.pos_y, got.heading, got.speed);
                error_count++;
            end else begin
                want = expected_states.pop_front();
                if (got.pos_x !== want.pos_x) begin
                    $display("%0t pos_x: expected %h actual %h", $time, want.pos_x, got.pos_x);
                    error_count++;
                end
                if (got.pos_y !== want.pos_y) begin
                    $display("%0t pos_y: expected %h actual %h", $time, want.pos_y, got.pos_y);
                    error_count++;
                end
                if (got.heading !== want.heading) begin
                    $display("%0t heading: expected %h actual %h",
                             $time, want.heading, got.heading);
                    error_count++;
                end
                if (got.speed !== want.speed) begin
                    $display("%0t speed: expected %h actual %h", $time, want.speed, got.speed);
                    error_count++;
                end
            end
        end
    end

    task automatic send_item(input logic cmd, input logic [2:0] keys,
                             input logic [15:0] delay);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {5'b0, delay, keys[2], keys[1], keys[0]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        advance_vehicle(cmd, keys, delay);
    endtask

    task automatic send_key(input logic [2:0] keys);
        send_item(hsdr_pkg::CMD_KEY, keys, 16'($urandom));
    endtask

    task automatic send_tick(input logic [15:0] delay);
        send_item(hsdr_pkg::CMD_TICK, 3'($urandom), delay);
    endtask

    // stop sending and wait until every transaction has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_states.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        drain_results();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            hsdr_pkg::REG_TURN_RATE:  turn_rate_m  = value[15:0];
            hsdr_pkg::REG_ACCEL_RATE: accel_rate_m = value;
            hsdr_pkg::REG_MAX_SPEED:  max_speed_m  = value;
            default: ;
        endcase
    endtask

    task automatic set_all_regs(input logic [15:0] turn, input logic [31:0] accel,
                                input logic [31:0] vmax);
        write_reg(hsdr_pkg::REG_TURN_RATE, 32'(turn));
        write_reg(hsdr_pkg::REG_ACCEL_RATE, accel);
        write_reg(hsdr_pkg::REG_MAX_SPEED, vmax);
    endtask

    // turning through every quadrant, cancelling keys, zero and full delay
    task automatic test_kinematics();
        send_tick(16'h0000);
        send_key(KEY_ACCEL | KEY_LEFT);
        send_tick(16'h0000);
        repeat (4) send_tick(16'hFFFF);
        send_key(KEY_ACCEL | KEY_LEFT | KEY_RIGHT);
        send_tick(16'h4000);
        send_key(KEY_RIGHT);
        repeat (3) send_tick(16'hFFFF);
        send_key(KEYS_NONE);
        send_tick(16'h8000);
    endtask

    // register extremes, clamp after lowering max_speed, floor at zero
    task automatic test_register_extremes();
        set_all_regs(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_key(KEY_ACCEL | KEY_LEFT);
        send_tick(16'hFFFF);
        send_tick(16'hFFFF);
        write_reg(hsdr_pkg::REG_MAX_SPEED, 32'd1000);
        send_tick(16'h0000);
        send_key(KEY_RIGHT);
        send_tick(16'hFFFF);
        set_all_regs(16'h0000, 32'h0000_0000, 32'h0000_0000);
        send_key(KEY_ACCEL);
        send_tick(16'hFFFF);
    endtask

    task automatic random_items(input int count);
        logic [15:0] delay;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                send_key(3'($urandom));
            end else begin
                delay = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 4096));
                send_tick(delay);
            end
        end
    endtask

    task automatic test_random_phases();
        logic [31:0] accel;
        logic [31:0] vmax;
        for (int ph = 0; ph < 9; ph++) begin
            case ($urandom_range(0, 3))
                0: accel = $urandom;
                1: accel = 32'($urandom_range(0, 1 << 18));
                2: accel = 32'($urandom_range(0, 1 << 24));
                default: accel = (ph[0]) ? 32'hFFFF_FFFF : 32'h0000_0000;
            endcase
            case ($urandom_range(0, 3))
                0: vmax = $urandom;
                1: vmax = 32'($urandom_range(0, 1 << 22));
                2: vmax = 32'hFFFF_FFFF;
                default: vmax = 32'($urandom_range(0, 1 << 16));
            endcase
            set_all_regs(16'($urandom), accel, vmax);
            quiet = (ph == 4);
            random_items(55);
            if (ph == 2) drain_results();
            random_items(55);
        end
        quiet = 1'b0;
    endtask

    task automatic test_no_idle_tail();
        set_all_regs(16'($urandom), 32'($urandom_range(0, 1 << 20)), $urandom);
        quiet = 1'b1;
        random_items(100);
    endtask

    initial begin
        turn_rate_m  = hsdr_pkg::TURN_RATE_RST;
        accel_rate_m = hsdr_pkg::ACCEL_RATE_RST;
        max_speed_m  = hsdr_pkg::MAX_SPEED_RST;
        accel_flag_m = 1'b0;
        left_flag_m  = 1'b0;
        right_flag_m = 1'b0;
        heading_m    = '0;
        speed_m      = '0;
        pos_x_m      = '0;
        pos_y_m      = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_kinematics();
        test_register_extremes();
        test_random_phases();
        test_no_idle_tail();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/hsdr_pkg.sv
design/hsdr_regs.sv
design/hsdr_ctrl.sv
design/hsdr_dp.sv
design/heading_speed_dead_reckoning.sv
verif/tb_top.sv
